/* design/bdac_pkg.sv */
package bdac_pkg;

    // Bits in one packed BCD digit.
    localparam int DIGIT_W = 4;

    // Width of one ASCII digit character on the result channel.
    localparam int CHAR_W = 6;

    // ASCII code of '0', as it appears in six bits.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // A BCD digit of five or more takes a correction of three before the shift.
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

endpackage

/* design/binary_to_decimal_ascii_top.sv */
// Channel  | Valid / Ready      | Payload
// ---------+--------------------+-------------------------------------------
// input    | s_valid / s_ready  | s_value [VALUE_WIDTH-1:0]
// result   | m_valid / m_ready  | m_digit_char [5:0], m_last_digit
//
// An item is loaded, then passes through VALUE_WIDTH shared double-dabble steps, then
// a digit phase walks the BCD digit positions while leading zeros are dropped and
// digits leave one per beat.
// s_ready is high only while the sequencer is idle; a result stall holds it in the
// digit phase, and the result register lets the next item load while the last beat waits.
// Reset (aresetn low, synchronous) clears the sequencer and m_valid.
module binary_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [VALUE_WIDTH-1:0]       s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bdac_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                         m_last_digit
);
    import bdac_pkg::*;

    // Decimal digits needed for the largest value: floor(W * log10(2)) + 1.
    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * DIGIT_W;
    localparam int BIT_CW = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CW = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CW-1:0]    bits_reg, bits_next;
    logic [DIG_CW-1:0]    rem_reg, rem_next;
    logic                 started_reg, started_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic [BCD_W-1:0]     bcd_step;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 out_free;

    // Shared shift-and-correct step.
    bdac_dabble_unit #(
        .NDIG (NDIG)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (bin_reg[VALUE_WIDTH-1]),
        .bcd_out (bcd_step)
    );

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer and result register next values.
    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bits_next    = bits_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        // The current beat leaves when the sink takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bin_next   = s_value;
                    bcd_next   = '0;
                    bits_next  = BIT_CW'(VALUE_WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next  = bcd_step;
                bin_next  = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bits_next = bits_reg - 1'b1;
                if (bits_reg == BIT_CW'(1)) begin
                    rem_next     = DIG_CW'(NDIG);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Leading zeros are dropped; the units digit always goes out.
                if (!started_reg && top_digit == '0 && rem_reg != DIG_CW'(1)) begin
                    bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next = rem_reg - 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = ASCII_ZERO + CHAR_W'(top_digit);
                    last_next    = (rem_reg == DIG_CW'(1));
                    started_next = 1'b1;
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next     = rem_reg - 1'b1;
                    if (rem_reg == DIG_CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bits_reg    <= bits_next;
        rem_reg     <= rem_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

    // An accepted item keeps the input closed in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a conversion was starting");

    // Every beat carries a decimal digit character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= ASCII_ZERO && m_digit_char <= ASCII_ZERO + 6'd9))
        else $error("result beat is not a decimal digit");

    // The sequencer returns to idle only with the last digit of the run, marked last, on the result channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (m_valid && m_last_digit))
        else $error("digit run left the digit phase without a last digit");

    // Reset leaves the block idle with no beat pending.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear the sequencer");

endmodule

/* design/bdac_dabble_unit.sv */
module bdac_dabble_unit #(
    parameter int NDIG = 10
) (
    input  logic [NDIG*bdac_pkg::DIGIT_W-1:0] bcd_in,
    input  logic                              bit_in,
    output logic [NDIG*bdac_pkg::DIGIT_W-1:0] bcd_out
);
    import bdac_pkg::*;

    localparam int BCD_W = NDIG * DIGIT_W;

    logic [BCD_W-1:0] corrected;

    // One double-dabble step: correct every digit that is five or more,
    // then shift the whole BCD word left and bring in the next binary bit.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_in[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
                corrected[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                corrected[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign bcd_out = {corrected[BCD_W-2:0], bit_in};

endmodule
